FILE: rtl/pcba_pkg.sv
// Shared types, constants and controller states of the per-channel buffer slot allocator.
package pcba_pkg;

    localparam int NUM_CHANNELS_DEF      = 2048;
    localparam int NUM_BUFFERS_DEF       = 3;
    localparam int SLOTS_PER_CHANNEL_DEF = 64;

    localparam int RES_ID_W  = 11;
    localparam int TIME_W    = 16;
    localparam int PHASE_W   = 16;
    localparam int BUF_OUT_W = 2;
    localparam int SLOT_W    = 6;
    localparam int COUNT_W   = 7;
    localparam int TOTAL_W   = 17;
    localparam int CFG_W     = 16;
    localparam int GEN_W     = 8;

    localparam logic [TIME_W-1:0]  TIME_WRAP = 16'hFFFF;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 17'h1FFFF;
    localparam logic [GEN_W-1:0]   GEN_MAX   = '1;

    localparam logic [CFG_W-1:0] TOTAL_LIMIT_RST = 16'd4096;
    localparam logic [CFG_W-1:0] TIME_LIMIT_RST  = 16'd1000;

    localparam logic REG_TOTAL_LIMIT = 1'b0;
    localparam logic REG_TIME_LIMIT  = 1'b1;

    typedef struct packed {
        logic                       restart;
        logic [RES_ID_W-1:0]        res_id;
        logic [TIME_W-1:0]          event_time;
        logic signed [PHASE_W-1:0]  phase;
    } pcba_in_t;

    typedef struct packed {
        logic [BUF_OUT_W-1:0]       buffer_index;
        logic [RES_ID_W-1:0]        channel;
        logic [SLOT_W-1:0]          slot;
        logic [TIME_W-1:0]          time_out;
        logic signed [PHASE_W-1:0]  phase_out;
        logic [COUNT_W-1:0]         new_count;
        logic                       rotated;
        logic [BUF_OUT_W-1:0]       buf_after;
    } pcba_out_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DIV,
        ST_RED,
        ST_READ,
        ST_CALC,
        ST_CLEAR,
        ST_DONE
    } pcba_state_t;

    typedef struct packed {
        logic load_in;
        logic div_step;
        logic red_step;
        logic rd_step;
        logic calc_step;
        logic sweep_en;
        logic wr_en;
        logic out_load;
    } pcba_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic need_sweep;
    } pcba_status_t;

endpackage

FILE: rtl/pcba_ctrl.sv
// Controller state machine of the per-channel buffer slot allocator.
module pcba_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  pcba_pkg::pcba_status_t status,
    output pcba_pkg::pcba_cmd_t    cmd
);
    import pcba_pkg::*;

    pcba_state_t state_reg;
    pcba_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (status.sweep_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_DIV;
            end
            ST_DIV:  state_next = ST_RED;
            ST_RED:  state_next = ST_READ;
            ST_READ: state_next = ST_CALC;
            ST_CALC:
            begin
                if (status.need_sweep)
                    state_next = ST_CLEAR;
                else
                    state_next = ST_DONE;
            end
            ST_CLEAR:
            begin
                if (status.sweep_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_INIT;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_INIT:  cmd.sweep_en = 1'b1;
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_DIV:   cmd.div_step  = 1'b1;
            ST_RED:   cmd.red_step  = 1'b1;
            ST_READ:  cmd.rd_step   = 1'b1;
            ST_CALC:  cmd.calc_step = 1'b1;
            ST_CLEAR: cmd.sweep_en  = 1'b1;
            ST_DONE:
            begin
                // rewrite of the same entry while stalled is harmless
                cmd.wr_en    = 1'b1;
                cmd.out_load = slot_free;
            end
            default: cmd = '0;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/pcba_dpath.sv
// Datapath of the per-channel buffer slot allocator: counter memory, window state, result.
module pcba_dpath #(
    parameter int NUM_CHANNELS      = pcba_pkg::NUM_CHANNELS_DEF,
    parameter int NUM_BUFFERS       = pcba_pkg::NUM_BUFFERS_DEF,
    parameter int SLOTS_PER_CHANNEL = pcba_pkg::SLOTS_PER_CHANNEL_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_index,
    input  logic [pcba_pkg::CFG_W-1:0] cfg_data,
    input  pcba_pkg::pcba_in_t        in_data,
    output pcba_pkg::pcba_out_t       out_data,
    input  pcba_pkg::pcba_cmd_t       cmd,
    output pcba_pkg::pcba_status_t    status
);
    import pcba_pkg::*;

    localparam int ROW_W     = $clog2(NUM_CHANNELS);
    localparam int BUF_W     = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam int CNT_W     = $clog2(SLOTS_PER_CHANNEL + 1);
    localparam int ENTRY_W   = GEN_W + CNT_W;
    localparam int DIV_SHIFT = RES_ID_W + ROW_W;
    localparam int MULT_W    = RES_ID_W + 2;
    localparam int PROD_W    = RES_ID_W + MULT_W;
    localparam int REM_W     = RES_ID_W + ROW_W + 1;
    localparam longint DIV_MULT_L =
        ((longint'(1) << DIV_SHIFT) + NUM_CHANNELS - 1) / NUM_CHANNELS;
    localparam logic [MULT_W-1:0] DIV_MULT = MULT_W'(DIV_MULT_L);

    // counter memory: each entry holds a generation tag and a fill count
    logic [ENTRY_W-1:0] mem [NUM_CHANNELS];
    logic [ENTRY_W-1:0] rd_reg;

    logic [CFG_W-1:0]   total_limit_reg;
    logic [CFG_W-1:0]   time_limit_reg;

    pcba_in_t           in_reg;
    logic [RES_ID_W-1:0] quot_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   sweep_cnt_reg;
    logic [GEN_W-1:0]   gen_reg;
    logic [BUF_W-1:0]   buf_reg;
    logic [TOTAL_W-1:0] events_reg;
    logic [TIME_W-1:0]  window_reg;
    logic               seen_reg;
    logic [CNT_W-1:0]   new_cnt_reg;
    pcba_out_t          res_reg;
    pcba_out_t          out_reg;

    logic [PROD_W-1:0]  prod;
    logic [REM_W-1:0]   rem;

    logic [CNT_W-1:0]   old_cnt;
    logic [CNT_W-1:0]   new_cnt;
    logic [BUF_W-1:0]   buf_base;
    logic [BUF_W-1:0]   buf_next;
    logic [TOTAL_W-1:0] events_base;
    logic [TOTAL_W-1:0] events_inc;
    logic [TIME_W-1:0]  window_base;
    logic               seen_base;
    logic [TIME_W-1:0]  elapsed;
    logic               rot;
    logic               bump;

    // row = res_id mod NUM_CHANNELS, quotient by reciprocal multiply
    assign prod = PROD_W'(in_reg.res_id) * PROD_W'(DIV_MULT);
    assign rem  = REM_W'(in_reg.res_id) - REM_W'(quot_reg) * REM_W'(NUM_CHANNELS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_limit_reg <= TOTAL_LIMIT_RST;
            time_limit_reg  <= TIME_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_TOTAL_LIMIT: total_limit_reg <= cfg_data;
                REG_TIME_LIMIT:  time_limit_reg  <= cfg_data;
                default:         total_limit_reg <= total_limit_reg;
            endcase
        end
    end

    always_comb
    begin
        old_cnt     = (in_reg.restart || rd_reg[ENTRY_W-1:CNT_W] != gen_reg)
                      ? '0 : rd_reg[CNT_W-1:0];
        new_cnt     = old_cnt + CNT_W'(1);
        buf_base    = in_reg.restart ? '0 : buf_reg;
        events_base = in_reg.restart ? '0 : events_reg;
        window_base = in_reg.restart ? '0 : window_reg;
        seen_base   = in_reg.restart ? 1'b0 : seen_reg;
        events_inc  = (events_base < TOTAL_MAX) ? events_base + TOTAL_W'(1) : events_base;
        if (window_base > in_reg.event_time)
            elapsed = in_reg.event_time + (TIME_WRAP - window_base);
        else
            elapsed = in_reg.event_time - window_base;
        rot = (events_inc > TOTAL_W'(total_limit_reg))
           || (new_cnt >= CNT_W'(SLOTS_PER_CHANNEL))
           || ((elapsed > time_limit_reg) && seen_base);
        buf_next = (buf_base == BUF_W'(NUM_BUFFERS - 1)) ? '0 : buf_base + BUF_W'(1);
        bump     = in_reg.restart || rot;
    end

    assign status.need_sweep = bump && (gen_reg == GEN_MAX);
    assign status.sweep_last = (sweep_cnt_reg == ROW_W'(NUM_CHANNELS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg <= '0;
            gen_reg       <= '0;
            buf_reg       <= '0;
            events_reg    <= '0;
            window_reg    <= '0;
            seen_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.sweep_en)
                sweep_cnt_reg <= status.sweep_last ? '0 : sweep_cnt_reg + ROW_W'(1);
            if (cmd.calc_step)
            begin
                // wrap of the tag goes through a full clearing pass
                if (bump)
                    gen_reg <= gen_reg + GEN_W'(1);
                buf_reg    <= rot ? buf_next : buf_base;
                events_reg <= rot ? '0 : events_inc;
                window_reg <= rot ? in_reg.event_time : window_base;
                seen_reg   <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            in_reg <= in_data;
        if (cmd.div_step)
            quot_reg <= RES_ID_W'(prod >> DIV_SHIFT);
        if (cmd.red_step)
            row_reg <= ROW_W'(rem);
        if (cmd.calc_step)
        begin
            new_cnt_reg           <= new_cnt;
            res_reg.buffer_index  <= BUF_OUT_W'(buf_base);
            res_reg.channel       <= RES_ID_W'(row_reg);
            res_reg.slot          <= SLOT_W'(old_cnt);
            res_reg.time_out      <= in_reg.event_time;
            res_reg.phase_out     <= in_reg.phase;
            res_reg.new_count     <= COUNT_W'(new_cnt);
            res_reg.rotated       <= rot;
            res_reg.buf_after     <= BUF_OUT_W'(rot ? buf_next : buf_base);
        end
        if (cmd.out_load)
            out_reg <= res_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sweep_en)
            mem[sweep_cnt_reg] <= '0;
        else if (cmd.wr_en && !res_reg.rotated)
            mem[row_reg] <= {gen_reg, new_cnt_reg};
        if (cmd.rd_step)
            rd_reg <= mem[row_reg];
    end

    assign out_data = out_reg;

endmodule

FILE: rtl/per_channel_buffer_slot_allocator.sv
// Top level of the per-channel buffer slot allocator.
// Usage:
//   Events enter on in_valid/in_ready/in_data; one result item per event leaves on
//   out_valid/out_ready/out_data. The result names the buffer, channel row and slot
//   to write, the channel's new fill count, whether the event rotated buffers and
//   the buffer in use afterward.
//   cfg_wr_en/cfg_index/cfg_data write total_limit (index 0) and time_limit
//   (index 1); write them only while no event is in flight.
// Timing:
//   One event at a time: the next event is taken only after the previous result
//   is loaded into the output register. Steps in order: modulo reduction (divide,
//   reduce), counter memory read, update, result load.
//   Counters are cleared by a generation tag; every 256th restart or rotation
//   the tag wraps and a clearing pass over all NUM_CHANNELS entries is added.
// Reset:
//   A clearing pass over all NUM_CHANNELS entries zeroes the counter memory; in_ready
//   stays low until it ends. Limits return to 4096 and 1000.
// Stall:
//   A result waits in the output register; the block finishes the next event up
//   to its result and holds there until the register is free.
module per_channel_buffer_slot_allocator #(
    parameter int NUM_CHANNELS      = pcba_pkg::NUM_CHANNELS_DEF,
    parameter int NUM_BUFFERS       = pcba_pkg::NUM_BUFFERS_DEF,
    parameter int SLOTS_PER_CHANNEL = pcba_pkg::SLOTS_PER_CHANNEL_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_index,
    input  logic [pcba_pkg::CFG_W-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  pcba_pkg::pcba_in_t         in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output pcba_pkg::pcba_out_t        out_data
);
    import pcba_pkg::*;

    pcba_cmd_t    cmd;
    pcba_status_t status;

    pcba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    pcba_dpath #(
        .NUM_CHANNELS      (NUM_CHANNELS),
        .NUM_BUFFERS       (NUM_BUFFERS),
        .SLOTS_PER_CHANNEL (SLOTS_PER_CHANNEL)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
